/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the transposition table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ZT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// cond must never be true outside reset
`define ZT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* design/zt_pkg.sv */
// ---------------------------------------------------------------------------
// zt_pkg
// Constants, codes and types of the Zobrist transposition table.
// ---------------------------------------------------------------------------
package zt_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int BOARD_SIZE  = 15;
  localparam int PIECE_KINDS = 6;

  localparam int CELL_COUNT  = PIECE_KINDS * BOARD_SIZE * BOARD_SIZE;
  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int SLOT_AW     = INDEX_BITS + 1;
  localparam int SLOT_COUNT  = 2 ** SLOT_AW;

  localparam int MODE_W  = 3;
  localparam int PIECE_W = 3;
  localparam int POS_W   = 4;
  localparam int SKEY_W  = 32;
  localparam int LKEY_W  = 64;
  localparam int SCORE_W = 28;
  localparam int DEPTH_W = 4;
  localparam int BOUND_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 3'd0,
    MODE_CLEAR  = 3'd1,
    MODE_TOGGLE = 3'd2,
    MODE_STORE  = 3'd3,
    MODE_LOOKUP = 3'd4
  } mode_t;

  // bound code three is legal on input and acts as an alpha bound
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_ALPHA = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_BETA  = 2'd2;

  typedef struct packed {
    logic [SKEY_W-1:0] skey;
    logic [LKEY_W-1:0] lkey;
  } cell_key_t;

  typedef struct packed {
    logic                 valid;
    logic [LKEY_W-1:0]    check;
    logic [BOUND_W-1:0]   bound;
    logic [DEPTH_W-1:0]   depth;
    logic [SCORE_W-1:0]   value;
  } slot_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    cell_key_t          data;
  } cell_wr_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    slot_t              data;
  } tbl_wr_t;

  function automatic logic cell_in_range(input logic [PIECE_W-1:0] piece,
                                         input logic [POS_W-1:0]   row,
                                         input logic [POS_W-1:0]   col);
    cell_in_range = (32'(piece) < PIECE_KINDS) && (32'(row) < BOARD_SIZE) &&
                    (32'(col) < BOARD_SIZE);
  endfunction

  // only meaningful when the cell is in range; the true value then fits
  function automatic logic [CELL_AW-1:0] cell_index(input logic [PIECE_W-1:0] piece,
                                                    input logic [POS_W-1:0]   row,
                                                    input logic [POS_W-1:0]   col);
    cell_index = CELL_AW'(piece) * CELL_AW'(BOARD_SIZE * BOARD_SIZE) +
                 CELL_AW'(row) * CELL_AW'(BOARD_SIZE) + CELL_AW'(col);
  endfunction

endpackage

/* design/zt_in_if.sv */
// ---------------------------------------------------------------------------
// zt_in_if
// Input item channel: valid/ready handshake with the request fields.
// ---------------------------------------------------------------------------
interface zt_in_if;
  logic                                valid;
  logic                                ready;
  logic        [zt_pkg::MODE_W-1:0]    mode;
  logic        [zt_pkg::PIECE_W-1:0]   piece;
  logic        [zt_pkg::POS_W-1:0]     row;
  logic        [zt_pkg::POS_W-1:0]     col;
  logic        [zt_pkg::SKEY_W-1:0]    key_short;
  logic        [zt_pkg::LKEY_W-1:0]    key_long;
  logic                                side;
  logic signed [zt_pkg::SCORE_W-1:0]   score;
  logic        [zt_pkg::DEPTH_W-1:0]   depth;
  logic        [zt_pkg::BOUND_W-1:0]   bound;
  logic signed [zt_pkg::SCORE_W-1:0]   alpha;
  logic signed [zt_pkg::SCORE_W-1:0]   beta;

  modport source (output valid, mode, piece, row, col, key_short, key_long, side,
                  score, depth, bound, alpha, beta, input ready);
  modport sink   (input valid, mode, piece, row, col, key_short, key_long, side,
                  score, depth, bound, alpha, beta, output ready);
endinterface

/* design/zt_out_if.sv */
// ---------------------------------------------------------------------------
// zt_out_if
// Result item channel: valid/ready handshake with the result fields.
// ---------------------------------------------------------------------------
interface zt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [zt_pkg::SCORE_W-1:0] value;
  logic                              written;

  modport source (output valid, hit, value, written, input ready);
  modport sink   (input valid, hit, value, written, output ready);
endinterface

/* design/zt_ram.sv */
// ---------------------------------------------------------------------------
// zt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module zt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/zt_sweep.sv */
// ---------------------------------------------------------------------------
// zt_sweep
// Post-reset clearing pass over the table memory; owns the write port
// until every entry has been cleared, then passes the controller through.
// ---------------------------------------------------------------------------
module zt_sweep (
  input  logic            clk,
  input  logic            rst_n,
  input  zt_pkg::tbl_wr_t req,
  output zt_pkg::tbl_wr_t wr,
  output logic            busy
);

  logic                       busy_r, busy_nxt;
  logic [zt_pkg::SLOT_AW-1:0] addr_r, addr_nxt;
  logic                       last;

  assign last = (addr_r == zt_pkg::SLOT_AW'(zt_pkg::SLOT_COUNT - 1));

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  always_comb begin
    if (busy_r) begin
      wr.we   = 1'b1;
      wr.addr = addr_r;
      wr.data = '0;
    end else begin
      wr = req;
    end
  end

  assign busy = busy_r;

endmodule

/* design/zt_ctrl.sv */
// ---------------------------------------------------------------------------
// zt_ctrl
// Item sequencer: issues the key and table reads on accept, then in the execute
// state decides load/store/lookup, updates the running keys and writes back.
// ---------------------------------------------------------------------------
module zt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  zt_in_if.sink                       in_ch,
  zt_out_if.source                    out_ch,
  input  logic                        busy,
  output logic                        cell_re,
  output logic [zt_pkg::CELL_AW-1:0]  cell_raddr,
  input  zt_pkg::cell_key_t           cell_rdata,
  output zt_pkg::cell_wr_t            cell_wr,
  output logic                        tbl_re,
  output logic [zt_pkg::SLOT_AW-1:0]  tbl_raddr,
  input  zt_pkg::slot_t               tbl_rdata,
  output zt_pkg::tbl_wr_t             tbl_req
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic        [zt_pkg::MODE_W-1:0]  mode;
    logic                              cell_ok;
    logic        [zt_pkg::CELL_AW-1:0] cidx;
    logic        [zt_pkg::SLOT_AW-1:0] slot;
    logic        [zt_pkg::SKEY_W-1:0]  key_short;
    logic        [zt_pkg::LKEY_W-1:0]  key_long;
    logic        [zt_pkg::SCORE_W-1:0] score;
    logic        [zt_pkg::DEPTH_W-1:0] depth;
    logic        [zt_pkg::BOUND_W-1:0] bound;
    logic signed [zt_pkg::SCORE_W-1:0] alpha;
    logic signed [zt_pkg::SCORE_W-1:0] beta;
  } item_t;

  state_t                       state_r, state_nxt;
  item_t                        item_r;
  logic [zt_pkg::SKEY_W-1:0]    rshort_r, rshort_nxt;
  logic [zt_pkg::LKEY_W-1:0]    rlong_r, rlong_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         hit_r;
  logic [zt_pkg::SCORE_W-1:0]   value_r;
  logic                         written_r;

  logic                         accept;
  logic                         done;
  logic                         keep;
  logic                         window_ok;
  logic                         hit;
  logic                         do_store;

  assign in_ch.ready = (state_r == S_IDLE) && !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  // results leave through the output register; wait only if it is still full
  assign done        = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // reads launch on accept, data is ready in the execute cycle
  assign cell_re    = accept;
  assign cell_raddr = zt_pkg::cell_index(in_ch.piece, in_ch.row, in_ch.col);
  assign tbl_re     = accept;
  assign tbl_raddr  = {in_ch.side, rshort_r[zt_pkg::INDEX_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.mode      <= in_ch.mode;
      item_r.cell_ok   <= zt_pkg::cell_in_range(in_ch.piece, in_ch.row, in_ch.col);
      item_r.cidx      <= cell_raddr;
      item_r.slot      <= tbl_raddr;
      item_r.key_short <= in_ch.key_short;
      item_r.key_long  <= in_ch.key_long;
      item_r.score     <= in_ch.score;
      item_r.depth     <= in_ch.depth;
      item_r.bound     <= in_ch.bound;
      item_r.alpha     <= in_ch.alpha;
      item_r.beta      <= in_ch.beta;
    end
  end

  // non-exact deeper entries are kept
  assign keep = tbl_rdata.valid && (tbl_rdata.bound != zt_pkg::BOUND_EXACT) &&
                (tbl_rdata.depth > item_r.depth);

  always_comb begin
    if (tbl_rdata.bound == zt_pkg::BOUND_EXACT) begin
      window_ok = 1'b1;
    end else if (tbl_rdata.bound == zt_pkg::BOUND_BETA) begin
      window_ok = $signed(tbl_rdata.value) <= item_r.beta;
    end else begin
      window_ok = $signed(tbl_rdata.value) >= item_r.alpha;
    end
  end

  assign hit = (item_r.mode == zt_pkg::MODE_LOOKUP) && tbl_rdata.valid &&
               (tbl_rdata.depth >= item_r.depth) && (tbl_rdata.check == rlong_r) &&
               window_ok;

  assign do_store = (item_r.mode == zt_pkg::MODE_STORE) && !keep;

  always_comb begin
    cell_wr.we        = done && (item_r.mode == zt_pkg::MODE_LOAD) && item_r.cell_ok;
    cell_wr.addr      = item_r.cidx;
    cell_wr.data.skey = item_r.key_short;
    cell_wr.data.lkey = item_r.key_long;

    tbl_req.we          = done && do_store;
    tbl_req.addr        = item_r.slot;
    tbl_req.data.valid  = 1'b1;
    tbl_req.data.check  = rlong_r;
    tbl_req.data.bound  = item_r.bound;
    tbl_req.data.depth  = item_r.depth;
    tbl_req.data.value  = item_r.score;
  end

  always_comb begin
    rshort_nxt = rshort_r;
    rlong_nxt  = rlong_r;
    if (done) begin
      unique case (item_r.mode)
        zt_pkg::MODE_CLEAR: begin
          rshort_nxt = '0;
          rlong_nxt  = '0;
        end
        zt_pkg::MODE_TOGGLE: begin
          if (item_r.cell_ok) begin
            rshort_nxt = rshort_r ^ cell_rdata.skey;
            rlong_nxt  = rlong_r ^ cell_rdata.lkey;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rshort_r    <= '0;
      rlong_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rshort_r    <= rshort_nxt;
      rlong_r     <= rlong_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      hit_r     <= hit;
      value_r   <= hit ? tbl_rdata.value : '0;
      written_r <= do_store;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.hit     = hit_r;
  assign out_ch.value   = value_r;
  assign out_ch.written = written_r;

endmodule

/* design/zobrist_transposition_table.sv */
// Sequence: an item is accepted, its key/table read completes in the execute
// state, and its result is registered once the output register can take it.
// Items: one at a time, set by the read-then-write-back sequence on the
// table and cell key memories; the next waits until the last is registered.
// Reset: running keys cleared; a clearing pass over all 8192 table entries
// wipes the table valid bits, during which no item is accepted.
// ---------------------------------------------------------------------------
// zobrist_transposition_table
// Zobrist-keyed game-search transposition table: cell key memory, running
// keys, and a two-sided table with depth/bound replacement and lookup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module zobrist_transposition_table (
  input logic      clk,
  input logic      rst_n,
  zt_in_if.sink    in_ch,
  zt_out_if.source out_ch
);

  logic                        sweep_busy;
  logic                        cell_re;
  logic [zt_pkg::CELL_AW-1:0]  cell_raddr;
  zt_pkg::cell_key_t           cell_rdata;
  zt_pkg::cell_wr_t            cell_wr;
  logic                        tbl_re;
  logic [zt_pkg::SLOT_AW-1:0]  tbl_raddr;
  zt_pkg::slot_t               tbl_rdata;
  zt_pkg::tbl_wr_t             tbl_req;
  zt_pkg::tbl_wr_t             tbl_wr;

  zt_ram #(
    .WIDTH($bits(zt_pkg::cell_key_t)),
    .DEPTH(zt_pkg::CELL_COUNT)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_wr.we),
    .waddr (cell_wr.addr),
    .wdata (cell_wr.data),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  zt_ram #(
    .WIDTH($bits(zt_pkg::slot_t)),
    .DEPTH(zt_pkg::SLOT_COUNT)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_wr.we),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  zt_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .wr    (tbl_wr),
    .busy  (sweep_busy)
  );

  zt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .busy       (sweep_busy),
    .cell_re    (cell_re),
    .cell_raddr (cell_raddr),
    .cell_rdata (cell_rdata),
    .cell_wr    (cell_wr),
    .tbl_re     (tbl_re),
    .tbl_raddr  (tbl_raddr),
    .tbl_rdata  (tbl_rdata),
    .tbl_req    (tbl_req)
  );

  `ZT_ASSERT_NEVER(a_accept_in_sweep, clk, rst_n, in_ch.valid && in_ch.ready && sweep_busy, "item accepted during clearing pass")
  `ZT_ASSERT(a_store_sets_valid, clk, rst_n, (tbl_wr.we && !sweep_busy) |-> tbl_wr.data.valid, "table store without valid bit")
  `ZT_ASSERT(a_one_at_a_time, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "second item accepted while one is in work")
  `ZT_ASSERT_NEVER(a_hit_and_write, clk, rst_n, out_ch.valid && out_ch.hit && out_ch.written, "result flags both hit and written")

endmodule

/* bench/zobrist_transposition_table_test.sv */
// ---------------------------------------------------------------------------
// zobrist_transposition_table_test
// Self-checking bench for the Zobrist transposition table. A directed table
// of requests covers reset, bound rules, depth replacement, spare modes and
// off-board cells. Random games follow: cell key loads, move toggles with
// undo, clears, stores and lookups. Every result item is checked against a
// fixed row result or an in-bench model of the keys and the table.
// ---------------------------------------------------------------------------
module zobrist_transposition_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import zt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 300_000;
  localparam int RANDOM_ITEMS = 1575;
  localparam int WARMUP_LOADS = 40;
  localparam int SETTLE       = 8;

  localparam logic [MODE_W-1:0]  MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0]  MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0]  MODE_SPARE7 = 3'd7;
  localparam logic [BOUND_W-1:0] BOUND_ALT_ALPHA = 2'd3;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_ONE = 28'sd1;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic [PIECE_W-1:0]         piece;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic [SKEY_W-1:0]          key_short;
    logic [LKEY_W-1:0]          key_long;
    logic                       side;
    logic signed [SCORE_W-1:0]  score;
    logic [DEPTH_W-1:0]         depth;
    logic [BOUND_W-1:0]         bound;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
  } req_t;

  typedef struct packed {
    logic                       hit;
    logic signed [SCORE_W-1:0]  value;
    logic                       written;
  } res_t;

  typedef struct {
    req_t req;
    bit   fixed;
    res_t res;
  } vector_t;

  localparam res_t NO_RESULT  = '{1'b0, '0, 1'b0};
  localparam res_t WROTE      = '{1'b0, '0, 1'b1};
  localparam res_t HIT_AT_MAX = '{1'b1, SCORE_MAX, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;
  int   fails = 0;
  int   cycles = 0;

  zt_in_if  in_ch();
  zt_out_if out_ch();

  zobrist_transposition_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // model state
  logic [SKEY_W-1:0] cell_skeys [CELL_COUNT];
  logic [LKEY_W-1:0] cell_lkeys [CELL_COUNT];
  logic [SKEY_W-1:0] run_skey = '0;
  logic [LKEY_W-1:0] run_lkey = '0;
  slot_t             slots [SLOT_COUNT];

  res_t pending_responses [$];

  // stimulus bookkeeping
  bit cell_seen [CELL_COUNT];
  int loaded_cells [$];
  int move_trail [$];
  vector_t directed [$];

  function automatic void add_row(input req_t req, input bit fixed, input res_t res);
    vector_t v;
    v.req = req;
    v.fixed = fixed;
    v.res = res;
    directed.insert(directed.size(), v);
  endfunction

  function automatic res_t table_response(req_t r);
    res_t               res;
    logic [SLOT_AW-1:0] slot;
    int                 cidx;
    bit                 on_board;
    bit                 usable;
    res = NO_RESULT;
    slot = {r.side, run_skey[INDEX_BITS-1:0]};
    on_board = r.piece < PIECE_KINDS && r.row < BOARD_SIZE && r.col < BOARD_SIZE;
    cidx = int'(r.piece) * BOARD_SIZE * BOARD_SIZE + int'(r.row) * BOARD_SIZE + int'(r.col);
    case (r.mode)
      MODE_LOAD: begin
        if (on_board) begin
          cell_skeys[cidx] = r.key_short;
          cell_lkeys[cidx] = r.key_long;
        end
      end
      MODE_CLEAR: begin
        run_skey = '0;
        run_lkey = '0;
      end
      MODE_TOGGLE: begin
        if (on_board) begin
          run_skey ^= cell_skeys[cidx];
          run_lkey ^= cell_lkeys[cidx];
        end
      end
      MODE_STORE: begin
        // a deeper non-exact bound is kept
        if (!(slots[slot].valid && slots[slot].bound != BOUND_EXACT &&
              slots[slot].depth > r.depth)) begin
          slots[slot] = '{valid: 1'b1, check: run_lkey, bound: r.bound,
                          depth: r.depth, value: r.score};
          res.written = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        if (slots[slot].valid && slots[slot].depth >= r.depth &&
            slots[slot].check == run_lkey) begin
          case (slots[slot].bound)
            BOUND_EXACT: usable = 1'b1;
            BOUND_BETA:  usable = $signed(slots[slot].value) <= r.beta;
            default:     usable = $signed(slots[slot].value) >= r.alpha;
          endcase
          if (usable) begin
            res.hit = 1'b1;
            res.value = slots[slot].value;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t cell_req(logic [MODE_W-1:0] mode, int piece, int row, int col,
                                    logic [SKEY_W-1:0] skey, logic [LKEY_W-1:0] lkey);
    req_t r;
    r = '{default: '0};
    r.mode = mode;
    r.piece = PIECE_W'(piece);
    r.row = POS_W'(row);
    r.col = POS_W'(col);
    r.key_short = skey;
    r.key_long = lkey;
    return r;
  endfunction

  function automatic req_t slot_req(logic [MODE_W-1:0] mode, logic side,
                                    logic signed [SCORE_W-1:0] score,
                                    logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound,
                                    logic signed [SCORE_W-1:0] alpha,
                                    logic signed [SCORE_W-1:0] beta);
    req_t r;
    r = '{default: '0};
    r.mode = mode;
    r.side = side;
    r.score = score;
    r.depth = depth;
    r.bound = bound;
    r.alpha = alpha;
    r.beta = beta;
    return r;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int unsigned p;
    int          v;
    p = $urandom_range(99);
    v = int'($urandom_range(80)) - 40;
    if (p < 70) return SCORE_W'(v);
    if (p < 78) return SCORE_MAX;
    if (p < 85) return SCORE_MIN;
    return SCORE_W'($urandom);
  endfunction

  function automatic void place(int c, ref req_t r);
    r.piece = PIECE_W'(c / (BOARD_SIZE * BOARD_SIZE));
    r.row = POS_W'((c / BOARD_SIZE) % BOARD_SIZE);
    r.col = POS_W'(c % BOARD_SIZE);
  endfunction

  // games: loads, moves with undo, clears, stores and lookups on the positions
  task automatic random_request(input int n, output req_t r);
    int unsigned p;
    int          c;
    r.mode = MODE_LOOKUP;
    r.piece = PIECE_W'($urandom);
    r.row = POS_W'($urandom);
    r.col = POS_W'($urandom);
    r.key_short = $urandom;
    r.key_long = {$urandom, $urandom};
    r.side = 1'($urandom);
    r.score = SCORE_W'($urandom);
    r.depth = DEPTH_W'($urandom);
    r.bound = BOUND_W'($urandom);
    r.alpha = SCORE_W'($urandom);
    r.beta = SCORE_W'($urandom);
    p = $urandom_range(99);
    if (n < WARMUP_LOADS || p < 8) begin
      c = $urandom_range(CELL_COUNT - 1);
      r.mode = MODE_LOAD;
      place(c, r);
      // crowd the index space so check keys get to disagree
      if ($urandom_range(1)) r.key_short[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(3));
      if (!cell_seen[c]) begin
        cell_seen[c] = 1'b1;
        loaded_cells.insert(loaded_cells.size(), c);
      end
    end else if (p < 11) begin
      r.mode = $urandom_range(1) ? MODE_LOAD : MODE_TOGGLE;
      case ($urandom_range(2))
        0:       r.piece = PIECE_W'($urandom_range(PIECE_KINDS, (1 << PIECE_W) - 1));
        1:       r.row = POS_W'($urandom_range(BOARD_SIZE, (1 << POS_W) - 1));
        default: r.col = POS_W'($urandom_range(BOARD_SIZE, (1 << POS_W) - 1));
      endcase
    end else if (p < 14) begin
      r.mode = MODE_W'($urandom_range(MODE_SPARE5, MODE_SPARE7));
    end else if (p < 17) begin
      r.mode = MODE_CLEAR;
      move_trail.delete();
    end else if (p < 42) begin
      r.mode = MODE_TOGGLE;
      if (move_trail.size() > 0 && $urandom_range(99) < 35) begin
        c = move_trail.pop_back();
      end else begin
        c = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
        move_trail.insert(move_trail.size(), c);
      end
      place(c, r);
    end else if (p < 68) begin
      r.mode = MODE_STORE;
      r.score = pick_score();
    end else begin
      r.alpha = pick_score();
      r.beta = pick_score();
    end
  endtask

  // called and returns at a falling edge
  task automatic send_item(input req_t r, input bit fixed, input res_t fixed_res);
    res_t res;
    while (!steady && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.mode <= r.mode;
    in_ch.piece <= r.piece;
    in_ch.row <= r.row;
    in_ch.col <= r.col;
    in_ch.key_short <= r.key_short;
    in_ch.key_long <= r.key_long;
    in_ch.side <= r.side;
    in_ch.score <= r.score;
    in_ch.depth <= r.depth;
    in_ch.bound <= r.bound;
    in_ch.alpha <= r.alpha;
    in_ch.beta <= r.beta;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = table_response(r);
    pending_responses.insert(pending_responses.size(), fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  always @(negedge clk) out_ch.ready <= steady || ($urandom_range(99) >= 19);

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_responses.size() == 0) begin
        $error("result item with no request pending");
        fails++;
      end else begin
        want = pending_responses.pop_front();
        if (out_ch.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_ch.hit);
          fails++;
        end
        if (out_ch.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_ch.value);
          fails++;
        end
        if (out_ch.written !== want.written) begin
          $error("written: expected %0d, got %0d", want.written, out_ch.written);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    req_t    r;
    int      n;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.piece = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.key_short = '0;
    in_ch.key_long = '0;
    in_ch.side = 1'b0;
    in_ch.score = '0;
    in_ch.depth = '0;
    in_ch.bound = '0;
    in_ch.alpha = '0;
    in_ch.beta = '0;
    out_ch.ready = 1'b0;
    for (n = 0; n < SLOT_COUNT; n++) slots[n] = '0;

    // empty table, exact hit, replacement by depth and bound, window edges
    add_row(slot_req(MODE_LOOKUP, 1'b0, '0, '0, BOUND_EXACT, SCORE_MIN, SCORE_MAX),
            1'b1, NO_RESULT);
    add_row(slot_req(MODE_STORE, 1'b0, SCORE_MAX, 4'd15, BOUND_EXACT, '0, '0),
            1'b1, WROTE);
    add_row(slot_req(MODE_LOOKUP, 1'b0, '0, 4'd15, BOUND_EXACT, SCORE_MIN, SCORE_MIN),
            1'b1, HIT_AT_MAX);
    add_row(slot_req(MODE_STORE, 1'b0, -28'sd5, 4'd0, BOUND_BETA, '0, '0),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_STORE, 1'b0, 28'sd7, 4'd0, BOUND_ALPHA, '0, '0),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_STORE, 1'b0, SCORE_MIN, 4'd15, BOUND_ALT_ALPHA, '0, '0),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_STORE, 1'b0, 28'sd9, 4'd14, BOUND_BETA, '0, '0),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_LOOKUP, 1'b0, '0, 4'd15, BOUND_EXACT, SCORE_MIN, SCORE_MAX),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_LOOKUP, 1'b0, '0, 4'd15, BOUND_EXACT, SCORE_MIN + SCORE_ONE,
                     SCORE_MAX), 1'b0, NO_RESULT);
    add_row(slot_req(MODE_STORE, 1'b1, 28'sd100, 4'd4, BOUND_BETA, '0, '0),
            1'b1, WROTE);
    add_row(slot_req(MODE_LOOKUP, 1'b1, '0, 4'd4, BOUND_EXACT, SCORE_MAX, 28'sd100),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_LOOKUP, 1'b1, '0, 4'd4, BOUND_EXACT, SCORE_MIN, 28'sd99),
            1'b0, NO_RESULT);
    add_row(slot_req(MODE_LOOKUP, 1'b1, '0, 4'd5, BOUND_EXACT, SCORE_MIN, SCORE_MAX),
            1'b0, NO_RESULT);
    // spare modes change nothing
    add_row(slot_req(MODE_SPARE5, 1'b1, SCORE_MAX, 4'd15, BOUND_ALT_ALPHA,
                     SCORE_MAX, SCORE_MAX), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_SPARE6, 7, 15, 15, '1, '1), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_SPARE7, 0, 0, 0, '1, '1), 1'b1, NO_RESULT);
    // corner cells, then off-board cells that must be ignored
    add_row(cell_req(MODE_LOAD, 0, 0, 0, '1, '1), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_LOAD, PIECE_KINDS - 1, BOARD_SIZE - 1, BOARD_SIZE - 1,
                     32'h1, 64'h8000_0000_0000_0000), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_LOAD, PIECE_KINDS, 0, 0, '1, '1), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_LOAD, 0, BOARD_SIZE, 0, '1, '1), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_LOAD, 0, 0, BOARD_SIZE, '1, '1), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_TOGGLE, 0, 0, 0, '0, '0), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_TOGGLE, PIECE_KINDS - 1, BOARD_SIZE - 1,
                     BOARD_SIZE - 1, '0, '0), 1'b1, NO_RESULT);
    add_row(cell_req(MODE_TOGGLE, PIECE_KINDS, 0, 0, '0, '0), 1'b1, NO_RESULT);
    add_row(slot_req(MODE_LOOKUP, 1'b0, '0, 4'd0, BOUND_EXACT, SCORE_MIN, SCORE_MAX),
            1'b0, NO_RESULT);
    add_row(cell_req(MODE_CLEAR, 0, 0, 0, '0, '0), 1'b1, NO_RESULT);
    add_row(slot_req(MODE_LOOKUP, 1'b0, '0, 4'd0, BOUND_EXACT, SCORE_MIN, SCORE_MAX),
            1'b0, NO_RESULT);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i].req, directed[i].fixed, directed[i].res);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 700 && n < 950);
      if (n == 400) begin
        // hold off until the block has answered everything
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_responses.size() != 0) @(negedge clk);
      end
      random_request(n, r);
      send_item(r, 1'b0, NO_RESULT);
    end
    in_ch.valid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/zt_pkg.sv
design/zt_in_if.sv
design/zt_out_if.sv
design/zt_ram.sv
design/zt_sweep.sv
design/zt_ctrl.sv
design/zobrist_transposition_table.sv
bench/zobrist_transposition_table_test.sv
